@@ rtl/core/stereo_mix_requantize_core_defines.svh @@
// Assertion macros shared by the checkers of the stereo mix requantizer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef STEREO_MIX_REQUANTIZE_CORE_DEFINES_SVH
`define STEREO_MIX_REQUANTIZE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMRQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/smrq_pkg.sv @@
// Shared types and constants of the stereo mix requantizer.
// No dependencies; used by the datapath, the top level and the checker.
package smrq_pkg;

    localparam int SUM_WIDTH_DEF = 32;
    localparam int IN_FIELD_W    = 32;
    localparam int PREC_W        = 5;
    localparam int PCT_W         = 7;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 16;
    localparam int M_TUSER_W     = 2;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 7;

    // Register indexes of the configuration channel.
    localparam logic [CFG_ADDR_W-1:0] CFG_STEREO_MODE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDE_SAMPLES = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNSIGNED_OUT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIX_PERCENT  = 2'd3;

    localparam logic [PREC_W-1:0] PREC_MIN       = 5'd8;
    localparam logic [PREC_W-1:0] PPS_BASE       = 5'd31;
    localparam logic [PREC_W-1:0] PCT_SHIFT_BASE = 5'd29;
    localparam logic [PREC_W-1:0] MONO_WIDE_REF  = 5'd15;
    localparam logic [PREC_W-1:0] MONO_NARROW_REF = 5'd7;
    localparam logic [PREC_W-1:0] WIDE_REF       = 5'd16;
    localparam logic [PREC_W-1:0] NARROW_REF     = 5'd8;
    localparam logic [PREC_W-1:0] MIX_SHIFT_WIDE   = 5'd16;
    localparam logic [PREC_W-1:0] MIX_SHIFT_NARROW = 5'd24;

    localparam logic [15:0] OFFSET_WIDE   = 16'd32768;
    localparam logic [7:0]  OFFSET_NARROW = 8'd128;

    // Percent term: floor(x / 25) by multiplying with a rounded-up reciprocal.
    // Exact while x * 8 < 2^33, and x stays below 2^28.
    localparam int    MIX_DIV   = 25;
    localparam int    X_W       = 28;
    localparam int    RECIP_SH  = 33;
    localparam int    RECIP_W   = 29;
    localparam longint RECIP_VAL = ((64'sd1 <<< RECIP_SH) + MIX_DIV - 1) / MIX_DIV;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_VAL);
    localparam int    TERM_W    = 24;
    localparam int    WGT_W     = TERM_W + 1;

    typedef struct packed {
        logic                 stereo_mode;
        logic                 wide_samples;
        logic                 unsigned_out;
        logic [PCT_W-1:0]     mix_percent;
    } t_cfg;

    typedef struct packed {
        logic [M_TDATA_W-1:0] sample;
        logic                 ovf;
    } t_res;

    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_pair;

endpackage

@@ rtl/core/stereo_mix_requantize_core.sv @@
// Stereo cross-mix and requantize block: sums in, 8- or 16-bit samples out.
// Depends on smrq_pkg and smrq_datapath.
//
// Usage: each input beat on the s-channel carries a left and a right
// accumulated sum and their precision. In stereo mode two output beats follow,
// left (channel 0) then right (channel 1, tlast high); in mono mode one beat
// with tlast high. Configuration registers are written on the cfg channel,
// which is always ready, and should be changed only while no beat is in flight.
// A left or mono beat passes the input, weight and products stages and the
// output pair register; a pair's right beat follows once the left is taken.
// Throughput: one input beat per cycle in mono and one per pair in stereo mode,
// set by the single output register: one sample a cycle unless tready is low.
// Four register stages (input, weight, products, output pair) let new input
// beats enter while a finished result waits on the m-channel.
// Reset clears all pipeline valid bits and loads the register defaults:
// stereo, 16-bit, signed, no mixing. When the receiver holds tready low the
// output beat holds, the stages behind it fill, and then s_tready drops.
module stereo_mix_requantize_core #(
    parameter int SUM_WIDTH = smrq_pkg::SUM_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [31:0] left_sum, [63:32] right_sum, [68:64] precision_bits, rest zero
    input  logic [smrq_pkg::S_TDATA_W-1:0]    i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [15:0] sample_out
    output logic [smrq_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // [0] channel, [1] overflow
    output logic [smrq_pkg::M_TUSER_W-1:0]    o_m_tuser,
    output logic                              o_m_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [smrq_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [smrq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import smrq_pkg::*;

    t_cfg  r_cfg;
    logic  r_d_valid;
    logic  r_d_idx;
    t_pair r_d_pair;
    logic  dp_valid;
    t_pair dp_pair;
    logic  m_fire, d_done, en_d;
    t_res  cur;

    smrq_datapath #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_left  (i_s_tdata[SUM_WIDTH-1:0]),
        .i_right (i_s_tdata[IN_FIELD_W +: SUM_WIDTH]),
        .i_prec  (i_s_tdata[2*IN_FIELD_W +: PREC_W]),
        .i_cfg   (r_cfg),
        .o_valid (dp_valid),
        .i_take  (en_d),
        .o_pair  (dp_pair)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stereo_mode  <= 1'b1;
            r_cfg.wide_samples <= 1'b1;
            r_cfg.unsigned_out <= 1'b0;
            r_cfg.mix_percent  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_STEREO_MODE:  r_cfg.stereo_mode  <= i_cfg_data[0];
                CFG_WIDE_SAMPLES: r_cfg.wide_samples <= i_cfg_data[0];
                CFG_UNSIGNED_OUT: r_cfg.unsigned_out <= i_cfg_data[0];
                CFG_MIX_PERCENT:  r_cfg.mix_percent  <= i_cfg_data[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The output pair register shows sample 0, then sample 1 for stereo items.
    assign m_fire = r_d_valid && i_m_tready;
    assign d_done = m_fire && (!r_d_pair.two || r_d_idx);
    assign en_d   = !r_d_valid || d_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_d_idx   <= 1'b0;
        end else if (en_d) begin
            r_d_valid <= dp_valid;
            r_d_idx   <= 1'b0;
        end else if (m_fire) begin
            r_d_idx   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) r_d_pair <= dp_pair;
    end

    assign cur        = r_d_idx ? r_d_pair.r1 : r_d_pair.r0;
    assign o_m_tvalid = r_d_valid;
    assign o_m_tdata  = cur.sample;
    assign o_m_tuser  = {cur.ovf, r_d_idx};
    assign o_m_tlast  = !r_d_pair.two || r_d_idx;

endmodule

@@ rtl/core/smrq_datapath.sv @@
// Three-stage requantizing datapath (input, weight, products), final shift after.
// Depends on smrq_pkg; instantiated by stereo_mix_requantize_core.
module smrq_datapath #(
    parameter int SUM_WIDTH = smrq_pkg::SUM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SUM_WIDTH-1:0]  i_left,
    input  logic signed [SUM_WIDTH-1:0]  i_right,
    input  logic [smrq_pkg::PREC_W-1:0]  i_prec,
    input  smrq_pkg::t_cfg               i_cfg,
    output logic                         o_valid,
    input  logic                         i_take,
    output smrq_pkg::t_pair              o_pair
);
    import smrq_pkg::*;

    localparam int DW    = SUM_WIDTH + 1;
    localparam int PW    = DW + WGT_W;
    localparam int VAL_W = PW + 1;

    function automatic t_res emit(input logic signed [VAL_W-1:0] v, input t_cfg c);
        t_res       r;
        logic [15:0] w;
        logic [7:0]  b;
        w = v[15:0] + (c.unsigned_out ? OFFSET_WIDE : 16'd0);
        b = v[7:0] + (c.unsigned_out ? OFFSET_NARROW : 8'd0);
        if (c.wide_samples) begin
            r.sample = w;
            r.ovf    = !((&v[VAL_W-1:15]) || !(|v[VAL_W-1:15]));
        end else begin
            r.sample = {8'd0, b};
            r.ovf    = !((&v[VAL_W-1:7]) || !(|v[VAL_W-1:7]));
        end
        return r;
    endfunction

    logic en_a, en_b, en_c;

    // Stage A: captured input beat.
    logic                        r_a_valid;
    logic signed [SUM_WIDTH-1:0] r_a_left, r_a_right;
    logic [PREC_W-1:0]           r_a_n;

    // Stage B: sum, difference and mixing weight.
    logic                        r_b_valid;
    logic signed [SUM_WIDTH-1:0] r_b_left, r_b_right;
    logic signed [DW-1:0]        r_b_sum, r_b_diff;
    logic [PREC_W-1:0]           r_b_n;
    logic signed [WGT_W-1:0]     r_b_weight;
    logic                        r_b_tz;

    // Stage C: products and plain-shift values.
    logic                        r_c_valid;
    logic signed [VAL_W-1:0]     r_c_s1, r_c_s2, r_c_pa, r_c_pb;
    logic                        r_c_mix, r_c_two;

    logic signed [DW-1:0]        a_sum, a_diff;
    logic [X_W-1:0]              a_x;
    logic [X_W+RECIP_W-1:0]      a_prod;
    logic [TERM_W-1:0]           a_term, a_pps;
    logic signed [WGT_W-1:0]     a_weight;

    logic signed [VAL_W-1:0]     b_l, b_r, b_s, b_s1, b_s2, b_pa, b_pb;
    logic signed [PW-1:0]        b_prod;
    logic                        b_mix;

    logic [PREC_W-1:0]           c_sh;
    logic signed [VAL_W-1:0]     c_sum, c_dif, c_va, c_vb;

    assign en_c    = !r_c_valid || i_take;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;
    assign o_valid = r_c_valid;

    always_comb begin
        a_sum  = {r_a_left[SUM_WIDTH-1], r_a_left} + {r_a_right[SUM_WIDTH-1], r_a_right};
        a_diff = {r_a_left[SUM_WIDTH-1], r_a_left} - {r_a_right[SUM_WIDTH-1], r_a_right};
        if (r_a_n < PCT_SHIFT_BASE) begin
            a_x = X_W'(i_cfg.mix_percent) << (PCT_SHIFT_BASE - r_a_n);
        end else begin
            a_x = X_W'(i_cfg.mix_percent >> (r_a_n - PCT_SHIFT_BASE));
        end
        a_prod   = a_x * RECIP_M;
        a_term   = a_prod[RECIP_SH +: TERM_W];
        a_pps    = TERM_W'(1) << (PPS_BASE - r_a_n);
        a_weight = $signed({1'b0, a_pps}) - $signed({1'b0, a_term});
    end

    always_comb begin
        b_l    = {{(VAL_W-SUM_WIDTH){r_b_left[SUM_WIDTH-1]}}, r_b_left};
        b_r    = {{(VAL_W-SUM_WIDTH){r_b_right[SUM_WIDTH-1]}}, r_b_right};
        b_s    = {{(VAL_W-DW){r_b_sum[DW-1]}}, r_b_sum};
        b_s1   = b_s <<< (PPS_BASE - r_b_n);
        b_prod = r_b_diff * r_b_weight;
        b_s2   = {b_prod[PW-1], b_prod};
        b_mix  = i_cfg.stereo_mode && !r_b_tz;
        b_pb   = '0;
        if (!i_cfg.stereo_mode) begin
            if (!i_cfg.wide_samples) begin
                b_pa = b_s >>> (r_b_n - MONO_NARROW_REF);
            end else if (r_b_n < MONO_WIDE_REF) begin
                b_pa = b_s <<< (MONO_WIDE_REF - r_b_n);
            end else begin
                b_pa = b_s >>> (r_b_n - MONO_WIDE_REF);
            end
        end else if (!i_cfg.wide_samples) begin
            b_pa = b_l >>> (r_b_n - NARROW_REF);
            b_pb = b_r >>> (r_b_n - NARROW_REF);
        end else if (r_b_n < WIDE_REF) begin
            b_pa = b_l <<< (WIDE_REF - r_b_n);
            b_pb = b_r <<< (WIDE_REF - r_b_n);
        end else begin
            b_pa = b_l >>> (r_b_n - WIDE_REF);
            b_pb = b_r >>> (r_b_n - WIDE_REF);
        end
    end

    always_comb begin
        c_sh  = i_cfg.wide_samples ? MIX_SHIFT_WIDE : MIX_SHIFT_NARROW;
        c_sum = r_c_s1 + r_c_s2;
        c_dif = r_c_s1 - r_c_s2;
        c_va  = r_c_mix ? (c_sum >>> c_sh) : r_c_pa;
        c_vb  = r_c_mix ? (c_dif >>> c_sh) : r_c_pb;
        o_pair.two = r_c_two;
        o_pair.r0  = emit(c_va, i_cfg);
        o_pair.r1  = emit(c_vb, i_cfg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_valid;
            if (en_b) r_b_valid <= r_a_valid;
            if (en_c) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_left  <= i_left;
            r_a_right <= i_right;
            r_a_n     <= (i_prec < PREC_MIN) ? PREC_MIN : i_prec;
        end
        if (en_b) begin
            r_b_left   <= r_a_left;
            r_b_right  <= r_a_right;
            r_b_sum    <= a_sum;
            r_b_diff   <= a_diff;
            r_b_n      <= r_a_n;
            r_b_weight <= a_weight;
            r_b_tz     <= (a_term == '0);
        end
        if (en_c) begin
            r_c_s1  <= b_s1;
            r_c_s2  <= b_s2;
            r_c_pa  <= b_pa;
            r_c_pb  <= b_pb;
            r_c_mix <= b_mix;
            r_c_two <= i_cfg.stereo_mode;
        end
    end

endmodule

@@ rtl/core/smrq_checker.sv @@
// Port-level checker for stereo_mix_requantize_core, attached by bind.
// Depends on smrq_pkg and stereo_mix_requantize_core_defines.svh.
`include "stereo_mix_requantize_core_defines.svh"

module smrq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [smrq_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input logic [smrq_pkg::M_TUSER_W-1:0]    o_m_tuser,
    input logic                              o_m_tlast
);

    logic                           m_stall;
    logic                           m_left_fire;
    logic                           m_right;
    logic                           m_right_last;
    logic                           m_nonlast;
    logic                           m_left;
    logic                           m_held;
    logic [smrq_pkg::M_TDATA_W-1:0] r_prev_tdata;
    logic [smrq_pkg::M_TUSER_W-1:0] r_prev_tuser;
    logic                           r_prev_tlast;

    always_ff @(posedge i_clk) begin
        r_prev_tdata <= o_m_tdata;
        r_prev_tuser <= o_m_tuser;
        r_prev_tlast <= o_m_tlast;
    end

    assign m_stall      = o_m_tvalid && !i_m_tready;
    assign m_left_fire  = o_m_tvalid && i_m_tready && !o_m_tlast;
    assign m_right      = o_m_tvalid && o_m_tuser[0];
    assign m_right_last = o_m_tvalid && o_m_tuser[0] && o_m_tlast;
    assign m_nonlast    = o_m_tvalid && !o_m_tlast;
    assign m_left       = !o_m_tuser[0];
    assign m_held       = o_m_tvalid && (o_m_tdata == r_prev_tdata)
                          && (o_m_tuser == r_prev_tuser) && (o_m_tlast == r_prev_tlast);

    // A stalled output beat keeps its payload.
    `SMRQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_stall, m_held, "stalled beat changed")

    // The left beat of a stereo pair is followed at once by its right beat.
    `SMRQ_ASSERT_NEXT(a_right_next, i_clk, i_rst_n, m_left_fire, m_right_last, "no right beat")

    // A right-channel beat always closes its item.
    `SMRQ_ASSERT_NOW(a_right_is_last, i_clk, i_rst_n, m_right, o_m_tlast, "right beat not last")

    // Only the left beat of a pair may be non-last.
    `SMRQ_ASSERT_NOW(a_nonlast_left, i_clk, i_rst_n, m_nonlast, m_left, "non-last right beat")

endmodule

bind stereo_mix_requantize_core smrq_checker u_smrq_checker (.*);
